// ===== rtl/scar_pkg.sv =====
// Package for the Scarabaeus curve trajectory block: field widths, register
// indexes, reset values and the elaboration-time sine table entry function.
// No dependencies; used by scar_sine_rom and scarabaeus_curve_trajectory.
`default_nettype none

package scar_pkg;

   localparam int PHASE_WIDTH = 16;
   localparam int COEFF_WIDTH = 16;
   localparam int POS_WIDTH   = 18;
   localparam int SINE_WIDTH  = 16;
   localparam int MAG_WIDTH   = 15;

   localparam int SINE_TABLE_ADDR_BITS_DEFAULT = 10;

   localparam logic signed [COEFF_WIDTH-1:0] COEFF_A_RESET = 16'sd9830;
   localparam logic signed [COEFF_WIDTH-1:0] COEFF_B_RESET = 16'sd6554;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_A = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_B = 1'b1;

   localparam logic [MAG_WIDTH-1:0] SINE_FULL_SCALE = 15'd16384;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HALF_Q16    = 64'sd32768;

   typedef longint taylor_div_type [1:8];
   localparam taylor_div_type TAYLOR_DIV = '{6, 20, 42, 72, 110, 156, 210, 272};

   // Sine of k/2^addr_bits quarter turns in Q2.14, from nine Taylor terms in Q30.
   function automatic logic [MAG_WIDTH-1:0] sine_entry(int unsigned k,
                                                         int unsigned addr_bits);
      longint x;
      longint term;
      longint sum;
      longint v;
      x    = (longint'(k) * HALF_PI_Q30) >>> addr_bits;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) / ONE_Q30;
         term = (term * x) / ONE_Q30;
         term = -term / TAYLOR_DIV[n];
         sum  = sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum + HALF_Q16) >>> 16;
      if (v > longint'(SINE_FULL_SCALE)) begin
         v = longint'(SINE_FULL_SCALE);
      end
      if (k == ((32'd1 << addr_bits))) begin
         v = longint'(SINE_FULL_SCALE);
      end
      return MAG_WIDTH'(v);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scar_sine_rom.sv =====
// Quarter-wave sine magnitude table with a registered read port.
// Contents are computed at elaboration with scar_pkg::sine_entry.
`default_nettype none

module scar_sine_rom #(
   parameter int ADDR_BITS = scar_pkg::SINE_TABLE_ADDR_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           enable,
   input  wire logic [ADDR_BITS:0]             addr,
   output logic      [scar_pkg::MAG_WIDTH-1:0] data
);
   import scar_pkg::*;

   localparam int DEPTH = (1 << ADDR_BITS) + 1;

   typedef logic [MAG_WIDTH-1:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k < DEPTH; k++) begin
         t[k] = sine_entry(k, ADDR_BITS);
      end
      return t;
   endfunction

   localparam rom_type ROM_TABLE = build_rom();

   logic [MAG_WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= ROM_TABLE[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/scarabaeus_curve_trajectory.sv =====
// Top level of the Scarabaeus curve trajectory block: five-stage pipeline.
// Depends on scar_pkg and three copies of scar_sine_rom.
//
// Each phase word becomes one point (pos_x, pos_y) on the Scarabaeus curve,
// r = b*cos(2phi) - a*cos(phi), x = sin(phi)*r, y = cos(phi)*r, a and b in
// Q2.14, x and y in Q4.14. The block takes one word per clock while the output
// side is ready. The three table reads are registered at the accepting edge,
// and the two coefficient multiplies, the subtract, the two output multiplies
// and the rounding into the output register each fill a register of their own,
// in that order.
// Each stage holds its word while the next one cannot take it, so stalls lose nothing.
// Coefficients are written through the csr port while the pipeline is empty; the block does not enforce it.
`default_nettype none

module scarabaeus_curve_trajectory #(
   parameter int SINE_TABLE_ADDR_BITS = scar_pkg::SINE_TABLE_ADDR_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [scar_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [scar_pkg::COEFF_WIDTH-1:0]       csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [scar_pkg::PHASE_WIDTH-1:0]       req_phase,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [scar_pkg::POS_WIDTH-1:0]       rsp_pos_x,
   output logic signed [scar_pkg::POS_WIDTH-1:0]       rsp_pos_y
);
   import scar_pkg::*;

   localparam int A          = SINE_TABLE_ADDR_BITS;
   localparam int DROP       = PHASE_WIDTH - 2 - A;
   localparam int TP_WIDTH   = A + 2;
   localparam int STAGES     = 5;
   localparam int PROD_WIDTH = 2 * COEFF_WIDTH;
   localparam int XY_WIDTH   = SINE_WIDTH + PROD_WIDTH - 1;
   localparam int RSHIFT     = 28;

   function automatic logic [A:0] tbl_index(logic [1:0] quad, logic [A-1:0] off);
      logic [A:0] o;
      o = {1'b0, off};
      return quad[0] ? ((A+1)'(1 << A) - o) : o;
   endfunction

   function automatic logic signed [SINE_WIDTH-1:0] apply_sign(logic neg,
                                                                logic [MAG_WIDTH-1:0] m);
      logic signed [SINE_WIDTH-1:0] v;
      v = $signed({1'b0, m});
      return neg ? -v : v;
   endfunction

   // Configuration registers.
   logic signed [COEFF_WIDTH-1:0] coeff_a_ff;
   logic signed [COEFF_WIDTH-1:0] coeff_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff <= COEFF_A_RESET;
         coeff_b_ff <= COEFF_B_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COEFF_A: coeff_a_ff <= $signed(csr_write_data);
            CSR_COEFF_B: coeff_b_ff <= $signed(csr_write_data);
         endcase
      end
   end

   // Valid bits and per-stage ready chain.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] stage_ready;

   always_comb begin
      stage_ready[STAGES-1] = ~valid_ff[STAGES-1] | rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = ~valid_ff[k] | stage_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ready = stage_ready[0];

   // Stage 1: table addresses and quadrant signs.
   logic [TP_WIDTH-1:0]    p1;
   logic [PHASE_WIDTH-1:0] phase_dbl;
   logic [TP_WIDTH-1:0]    p2;
   logic [1:0]             quad_s;
   logic [1:0]             quad_c;
   logic [1:0]             quad_c2;
   logic [A:0]             addr_s_in;
   logic [A:0]             addr_c_in;
   logic [A:0]             addr_c2_in;

   always_comb begin
      p1         = TP_WIDTH'(req_phase >> DROP);
      phase_dbl  = {req_phase[PHASE_WIDTH-2:0], 1'b0};
      p2         = TP_WIDTH'(phase_dbl >> DROP);
      quad_s     = p1[A+1:A];
      quad_c     = p1[A+1:A] + 2'd1;
      quad_c2    = p2[A+1:A] + 2'd1;
      addr_s_in  = tbl_index(quad_s, p1[A-1:0]);
      addr_c_in  = tbl_index(quad_c, p1[A-1:0]);
      addr_c2_in = tbl_index(quad_c2, p2[A-1:0]);
   end

   logic [MAG_WIDTH-1:0] mag_s;
   logic [MAG_WIDTH-1:0] mag_c;
   logic [MAG_WIDTH-1:0] mag_c2;
   logic                 neg_s_ff;
   logic                 neg_c_ff;
   logic                 neg_c2_ff;

   scar_sine_rom #(.ADDR_BITS(A)) u_rom_sin (
      .clock  (clock),
      .enable (stage_ready[0]),
      .addr   (addr_s_in),
      .data   (mag_s)
   );

   scar_sine_rom #(.ADDR_BITS(A)) u_rom_cos (
      .clock  (clock),
      .enable (stage_ready[0]),
      .addr   (addr_c_in),
      .data   (mag_c)
   );

   scar_sine_rom #(.ADDR_BITS(A)) u_rom_cos2 (
      .clock  (clock),
      .enable (stage_ready[0]),
      .addr   (addr_c2_in),
      .data   (mag_c2)
   );

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         neg_s_ff  <= quad_s[1];
         neg_c_ff  <= quad_c[1];
         neg_c2_ff <= quad_c2[1];
      end
   end

   // Stage 2: signed trig values and coefficient products.
   logic signed [SINE_WIDTH-1:0] sin_in;
   logic signed [SINE_WIDTH-1:0] cos_in;
   logic signed [SINE_WIDTH-1:0] cos2_in;
   logic signed [PROD_WIDTH-1:0] prod_b_in;
   logic signed [PROD_WIDTH-1:0] prod_a_in;
   logic signed [SINE_WIDTH-1:0] sin2_ff;
   logic signed [SINE_WIDTH-1:0] cos2_ff;
   logic signed [PROD_WIDTH-1:0] prod_b_ff;
   logic signed [PROD_WIDTH-1:0] prod_a_ff;

   always_comb begin
      sin_in    = apply_sign(neg_s_ff, mag_s);
      cos_in    = apply_sign(neg_c_ff, mag_c);
      cos2_in   = apply_sign(neg_c2_ff, mag_c2);
      prod_b_in = coeff_b_ff * cos2_in;
      prod_a_in = coeff_a_ff * cos_in;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         sin2_ff   <= sin_in;
         cos2_ff   <= cos_in;
         prod_b_ff <= prod_b_in;
         prod_a_ff <= prod_a_in;
      end
   end

   // Stage 3: radius in Q28.
   logic signed [PROD_WIDTH-1:0] radius_in;
   logic signed [PROD_WIDTH-1:0] radius_ff;
   logic signed [SINE_WIDTH-1:0] sin3_ff;
   logic signed [SINE_WIDTH-1:0] cos3_ff;

   assign radius_in = prod_b_ff - prod_a_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         radius_ff <= radius_in;
         sin3_ff   <= sin2_ff;
         cos3_ff   <= cos2_ff;
      end
   end

   // Stage 4: exact Q42 coordinate products.
   logic signed [XY_WIDTH-1:0] prod_x_in;
   logic signed [XY_WIDTH-1:0] prod_y_in;
   logic signed [XY_WIDTH-1:0] prod_x_ff;
   logic signed [XY_WIDTH-1:0] prod_y_ff;

   always_comb begin
      prod_x_in = sin3_ff * radius_ff;
      prod_y_in = cos3_ff * radius_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   // Stage 5: round to Q14 with ties upward.
   logic signed [XY_WIDTH-1:0]  round_x;
   logic signed [XY_WIDTH-1:0]  round_y;
   logic signed [POS_WIDTH-1:0] pos_x_in;
   logic signed [POS_WIDTH-1:0] pos_y_in;
   logic signed [POS_WIDTH-1:0] pos_x_ff;
   logic signed [POS_WIDTH-1:0] pos_y_ff;

   always_comb begin
      round_x  = prod_x_ff + XY_WIDTH'(64'sd1 <<< (RSHIFT - 1));
      round_y  = prod_y_ff + XY_WIDTH'(64'sd1 <<< (RSHIFT - 1));
      pos_x_in = $signed(round_x[RSHIFT+POS_WIDTH-1:RSHIFT]);
      pos_y_in = $signed(round_y[RSHIFT+POS_WIDTH-1:RSHIFT]);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;

   // Any empty stage lets the input side take a word.
   assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> req_ready)
      else $error("input stalled although the pipeline has a free stage");

   // A table read never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (mag_s <= SINE_FULL_SCALE) && (mag_c <= SINE_FULL_SCALE)
                      && (mag_c2 <= SINE_FULL_SCALE))
      else $error("sine table read above full scale");

   // Nothing is offered on the output right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

`default_nettype wire
